>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HES_ASSERT_NOW(name, ck, rn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define HES_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
	else $error(msg);

`endif

>>> design/hes_pkg.sv
package hes_pkg;

	localparam int DataW        = 32;
	localparam int IdxW         = 6;
	localparam int CountW       = 7;
	localparam int RegIdxW      = 3;
	localparam int SatW         = 72;
	localparam int DefMaxPoints = 64;
	localparam int DefFracBits  = 16;
	localparam int RstPointCount = 64;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	typedef enum logic [RegIdxW-1:0] {
		REG_POINT_COUNT   = 3'd0,
		REG_DIFFUSION     = 3'd1,
		REG_BOUNDARY_MODE = 3'd2,
		REG_LEFT_VALUE    = 3'd3,
		REG_RIGHT_VALUE   = 3'd4
	} hes_reg_t;

	typedef enum logic [2:0] {
		MS_R_LB,
		MS_R_RB,
		MS_CP_R,
		MS_R_DP,
		MS_CP_NXT
	} hes_msel_t;

	typedef struct packed {
		logic      load;
		logic      clr_fwd;
		logic      mul_en;
		hes_msel_t msel;
		logic      cap_blr;
		logic      cap_brr;
		logic      tmp_rd;
		logic      cap_den;
		logic      cap_rhs;
		logic      first;
		logic      final_pt;
		logic      div_start;
		logic      fwd_wr;
		logic      bwd_top;
		logic      cd_rd;
		logic      bwd_wr;
		logic      bnd_l;
		logic      bnd_r;
		logic      out_cap;
		logic      out_last;
	} hes_cmd_t;

	typedef struct packed {
		logic div_done;
	} hes_stat_t;

	function automatic logic signed [DataW-1:0] sat32(input logic signed [SatW-1:0] v);
		if (v[SatW-1:DataW-1] == '0 || v[SatW-1:DataW-1] == '1)
			return v[DataW-1:0];
		else if (v[SatW-1])
			return {1'b1, {(DataW-1){1'b0}}};
		else
			return {1'b0, {(DataW-1){1'b1}}};
	endfunction

	function automatic logic [DataW-1:0] mag32(input logic signed [DataW-1:0] v);
		return v[DataW-1] ? DataW'(-v) : DataW'(v);
	endfunction

endpackage

>>> design/hes_in_if.sv
interface hes_in_if;
	logic              valid;
	logic              ready;
	logic              op;
	logic [5:0]        point_index;
	logic signed [31:0] sample;

	modport source(output valid, op, point_index, sample, input ready);
	modport sink(input valid, op, point_index, sample, output ready);
endinterface

>>> design/hes_out_if.sv
interface hes_out_if;
	logic              valid;
	logic              ready;
	logic [5:0]        point_index_res;
	logic signed [31:0] temperature;
	logic              last;

	modport source(output valid, point_index_res, temperature, last, input ready);
	modport sink(input valid, point_index_res, temperature, last, output ready);
endinterface

>>> design/hes_ram.sv
module hes_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

>>> design/hes_div.sv
module hes_div #(
	parameter int NW = 69,
	parameter int DW = 36
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quo,
	output logic          done
);

	localparam int CntW = $clog2(NW + 1);

	logic            busy_q;
	logic [CntW-1:0] cnt_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   den_q;
	logic [NW-1:0]   nsh_q;
	logic [NW-1:0]   quo_q;
	logic [DW:0]     rsh;
	logic            ge;

	assign rsh  = {rem_q, nsh_q[NW-1]};
	assign ge   = rsh >= {1'b0, den_q};
	assign quo  = quo_q;
	assign done = ~busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CntW'(NW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CntW'(1);
			busy_q <= (cnt_q != CntW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			nsh_q <= num;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(rsh - {1'b0, den_q}) : DW'(rsh);
			nsh_q <= {nsh_q[NW-2:0], 1'b0};
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

endmodule

>>> design/hes_datapath.sv
module hes_datapath import hes_pkg::*; #(
	parameter int MAX_POINTS    = DefMaxPoints,
	parameter int FRACTION_BITS = DefFracBits
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          write_enable,
	input  logic [RegIdxW-1:0]            reg_index,
	input  logic [DataW-1:0]              write_data,
	input  logic [IdxW-1:0]               point_index,
	input  logic signed [DataW-1:0]       sample,
	input  hes_cmd_t                      cmd,
	input  logic [$clog2(MAX_POINTS)-1:0] addr,
	output hes_stat_t                     stat,
	output logic [$clog2(MAX_POINTS)-1:0] last_idx,
	output logic [IdxW-1:0]               point_index_res,
	output logic signed [DataW-1:0]       temperature,
	output logic                          last
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int PW = 65 - FRACTION_BITS;
	localparam int RW = PW + 3;
	localparam int DW = 36;
	localparam int NW = RW + FRACTION_BITS + 1;
	localparam int CW = (AW + 1 > CountW) ? AW + 1 : CountW;

	logic [CountW-1:0]       count_q;
	logic [DataW-1:0]        ratio_q;
	logic                    bmode_q;
	logic signed [DataW-1:0] left_q;
	logic signed [DataW-1:0] right_q;
	logic signed [DataW-1:0] lb;
	logic signed [DataW-1:0] rb;
	logic [CW-1:0]           cnt_ext;
	logic [CW-1:0]           n_clamp;

	logic [DataW-1:0]        ma;
	logic [DataW-1:0]        mb;
	logic                    mneg;
	logic [63:0]             prod_s1;
	logic                    neg_s1;
	logic [PW-1:0]           rnd_mag;
	logic signed [PW:0]      rnd;

	logic signed [PW:0]      blr_q;
	logic signed [PW:0]      brr_q;
	logic signed [DataW-1:0] cp_q;
	logic signed [DataW-1:0] dp_q;
	logic signed [DataW-1:0] nxt_q;
	logic signed [RW-1:0]    rhs_q;
	logic [DW-1:0]           den_q;
	logic [DW-1:0]           diag;
	logic signed [RW-1:0]    den_sum;
	logic [RW-1:0]           rhs_mag;
	logic [NW-1:0]           num_cp;
	logic [NW-1:0]           num_dp;
	logic [NW-1:0]           q_cp;
	logic [NW-1:0]           q_dp;
	logic                    done_cp;
	logic                    done_dp;
	logic signed [DataW-1:0] cp_new;
	logic signed [DataW-1:0] dp_new;
	logic signed [DataW-1:0] bwd_v;

	logic                    t_we;
	logic [AW-1:0]           t_waddr;
	logic [DataW-1:0]        t_wdata;
	logic [DataW-1:0]        t_rdata;
	logic [DataW-1:0]        cp_rdata;
	logic [DataW-1:0]        dp_rdata;
	logic                    load_ok;

	logic [IdxW-1:0]         out_idx_q;
	logic signed [DataW-1:0] out_temp_q;
	logic                    out_last_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CountW'(RstPointCount);
			ratio_q <= DataW'(1) << FRACTION_BITS;
			bmode_q <= 1'b1;
			left_q  <= '0;
			right_q <= '0;
		end else if (write_enable) begin
			unique case (reg_index)
				REG_POINT_COUNT:   count_q <= write_data[CountW-1:0];
				REG_DIFFUSION:     ratio_q <= write_data;
				REG_BOUNDARY_MODE: bmode_q <= write_data[0];
				REG_LEFT_VALUE:    left_q  <= write_data;
				REG_RIGHT_VALUE:   right_q <= write_data;
				default: ;
			endcase
		end
	end

	assign lb = bmode_q ? left_q : '0;
	assign rb = bmode_q ? right_q : '0;

	always_comb begin
		cnt_ext = CW'(count_q);
		if (cnt_ext < CW'(2))
			n_clamp = CW'(2);
		else if (cnt_ext > CW'(MAX_POINTS))
			n_clamp = CW'(MAX_POINTS);
		else
			n_clamp = cnt_ext;
	end

	assign last_idx = AW'(n_clamp - CW'(1));

	// shared multiplier on magnitudes, rounded half away from zero
	always_comb begin
		ma   = '0;
		mb   = '0;
		mneg = 1'b0;
		case (cmd.msel)
			MS_R_LB: begin
				ma = ratio_q; mb = mag32(lb); mneg = lb[DataW-1];
			end
			MS_R_RB: begin
				ma = ratio_q; mb = mag32(rb); mneg = rb[DataW-1];
			end
			MS_CP_R: begin
				ma = mag32(cp_q); mb = ratio_q; mneg = cp_q[DataW-1];
			end
			MS_R_DP: begin
				ma = ratio_q; mb = mag32(dp_q); mneg = dp_q[DataW-1];
			end
			MS_CP_NXT: begin
				ma   = mag32($signed(cp_rdata));
				mb   = mag32(nxt_q);
				mneg = cp_rdata[DataW-1] ^ nxt_q[DataW-1];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_s1 <= 64'(ma) * 64'(mb);
			neg_s1  <= mneg;
		end
	end

	assign rnd_mag = PW'((65'(prod_s1) + (65'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS);
	assign rnd     = neg_s1 ? -$signed({1'b0, rnd_mag}) : $signed({1'b0, rnd_mag});

	// forward sweep terms
	assign diag    = (DW'(1) << FRACTION_BITS) + (DW'(ratio_q) << 1);
	assign den_sum = $signed(RW'(diag)) + RW'(rnd);
	assign rhs_mag = rhs_q[RW-1] ? RW'(-rhs_q) : RW'(rhs_q);
	assign num_cp  = (NW'(ratio_q) << FRACTION_BITS) + NW'(den_q >> 1);
	assign num_dp  = (NW'(rhs_mag) << FRACTION_BITS) + NW'(den_q >> 1);
	assign cp_new  = DataW'(-q_cp);
	assign dp_new  = sat32(rhs_q[RW-1] ? -$signed(SatW'(q_dp)) : $signed(SatW'(q_dp)));
	assign bwd_v   = sat32(SatW'($signed(dp_rdata)) - SatW'(rnd));
	assign stat.div_done = done_cp & done_dp;

	always_ff @(posedge clk) begin
		if (cmd.cap_blr)
			blr_q <= rnd;
		if (cmd.cap_brr)
			brr_q <= rnd;
		if (cmd.cap_den)
			den_q <= (den_sum <= 0) ? DW'(1) : DW'(den_sum);
		if (cmd.cap_rhs)
			rhs_q <= RW'($signed(t_rdata)) + (cmd.first ? RW'(blr_q) : '0)
			       + (cmd.final_pt ? RW'(brr_q) : '0) + RW'(rnd);
		if (cmd.clr_fwd) begin
			cp_q <= '0;
			dp_q <= '0;
		end else if (cmd.fwd_wr) begin
			cp_q <= cp_new;
			dp_q <= dp_new;
		end
		if (cmd.bwd_top)
			nxt_q <= dp_q;
		else if (cmd.bwd_wr)
			nxt_q <= bwd_v;
		if (cmd.out_cap) begin
			out_idx_q  <= IdxW'(addr);
			out_temp_q <= t_rdata;
			out_last_q <= cmd.out_last;
		end
	end

	hes_div #(.NW(NW), .DW(DW)) u_div_cp (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(num_cp), .den(den_q), .quo(q_cp), .done(done_cp)
	);

	hes_div #(.NW(NW), .DW(DW)) u_div_dp (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(num_dp), .den(den_q), .quo(q_dp), .done(done_dp)
	);

	// temperature row write port
	assign load_ok = 32'(point_index) < 32'(MAX_POINTS);

	always_comb begin
		t_we    = 1'b0;
		t_waddr = addr;
		t_wdata = dp_q;
		if (cmd.load) begin
			t_we    = load_ok;
			t_waddr = AW'(point_index);
			t_wdata = sample;
		end else if (cmd.bwd_top) begin
			t_we = 1'b1;
		end else if (cmd.bwd_wr) begin
			t_we    = 1'b1;
			t_wdata = bwd_v;
		end else if (cmd.bnd_l) begin
			t_we    = 1'b1;
			t_wdata = lb;
		end else if (cmd.bnd_r) begin
			t_we    = 1'b1;
			t_wdata = rb;
		end
	end

	hes_ram #(.W(DataW), .DEPTH(MAX_POINTS)) u_row (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.re(cmd.tmp_rd), .raddr(addr), .rdata(t_rdata)
	);

	hes_ram #(.W(DataW), .DEPTH(MAX_POINTS)) u_cp (
		.clk(clk), .we(cmd.fwd_wr), .waddr(addr), .wdata(cp_new),
		.re(cmd.cd_rd), .raddr(addr), .rdata(cp_rdata)
	);

	hes_ram #(.W(DataW), .DEPTH(MAX_POINTS)) u_dp (
		.clk(clk), .we(cmd.fwd_wr), .waddr(addr), .wdata(dp_new),
		.re(cmd.cd_rd), .raddr(addr), .rdata(dp_rdata)
	);

	assign point_index_res = out_idx_q;
	assign temperature     = out_temp_q;
	assign last            = out_last_q;

endmodule

>>> design/hes_ctrl.sv
module hes_ctrl import hes_pkg::*; #(
	parameter int AW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          item_op,
	output logic          item_ready,
	output logic          res_valid,
	input  logic          res_ready,
	input  logic [AW-1:0] last_idx,
	input  hes_stat_t     stat,
	output hes_cmd_t      cmd,
	output logic [AW-1:0] addr
);

	typedef enum logic [4:0] {
		S_IDLE, S_PRE_L, S_PRE_R, S_PRE_W,
		S_F_M1, S_F_M2, S_F_RHS, S_F_DIVS, S_F_DIVW,
		S_B_TOP, S_B_RD, S_B_MUL, S_B_WR,
		S_BND_L, S_BND_R, S_E_RD, S_E_CAP, S_E_HOLD
	} state_t;

	state_t        state_q;
	logic [AW-1:0] i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_valid && item_op == OP_STEP)
						state_q <= S_PRE_L;
				end
				S_PRE_L: state_q <= S_PRE_R;
				S_PRE_R: state_q <= S_PRE_W;
				S_PRE_W: begin
					i_q     <= '0;
					state_q <= (last_idx == AW'(1)) ? S_BND_L : S_F_M1;
				end
				S_F_M1:   state_q <= S_F_M2;
				S_F_M2:   state_q <= S_F_RHS;
				S_F_RHS:  state_q <= S_F_DIVS;
				S_F_DIVS: state_q <= S_F_DIVW;
				S_F_DIVW: begin
					if (stat.div_done) begin
						if (i_q == last_idx - AW'(2)) begin
							state_q <= S_B_TOP;
						end else begin
							i_q     <= i_q + AW'(1);
							state_q <= S_F_M1;
						end
					end
				end
				S_B_TOP: begin
					if (last_idx == AW'(2)) begin
						state_q <= S_BND_L;
					end else begin
						i_q     <= last_idx - AW'(3);
						state_q <= S_B_RD;
					end
				end
				S_B_RD:  state_q <= S_B_MUL;
				S_B_MUL: state_q <= S_B_WR;
				S_B_WR: begin
					if (i_q == '0) begin
						state_q <= S_BND_L;
					end else begin
						i_q     <= i_q - AW'(1);
						state_q <= S_B_RD;
					end
				end
				S_BND_L: state_q <= S_BND_R;
				S_BND_R: begin
					i_q     <= '0;
					state_q <= S_E_RD;
				end
				S_E_RD:  state_q <= S_E_CAP;
				S_E_CAP: state_q <= S_E_HOLD;
				S_E_HOLD: begin
					if (res_ready) begin
						if (i_q == last_idx) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + AW'(1);
							state_q <= S_E_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign item_ready = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_E_HOLD);

	always_comb begin
		cmd  = '0;
		addr = i_q;
		unique case (state_q)
			S_IDLE:  cmd.load = item_valid && item_op == OP_LOAD;
			S_PRE_L: begin
				cmd.mul_en  = 1'b1;
				cmd.msel    = MS_R_LB;
				cmd.clr_fwd = 1'b1;
			end
			S_PRE_R: begin
				cmd.mul_en  = 1'b1;
				cmd.msel    = MS_R_RB;
				cmd.cap_blr = 1'b1;
			end
			S_PRE_W: cmd.cap_brr = 1'b1;
			S_F_M1: begin
				cmd.mul_en = 1'b1;
				cmd.msel   = MS_CP_R;
				cmd.tmp_rd = 1'b1;
				addr       = i_q + AW'(1);
			end
			S_F_M2: begin
				cmd.cap_den = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.msel    = MS_R_DP;
			end
			S_F_RHS: begin
				cmd.cap_rhs  = 1'b1;
				cmd.first    = (i_q == '0);
				cmd.final_pt = (i_q == last_idx - AW'(2));
			end
			S_F_DIVS: cmd.div_start = 1'b1;
			S_F_DIVW: cmd.fwd_wr    = stat.div_done;
			S_B_TOP: begin
				cmd.bwd_top = 1'b1;
				addr        = last_idx - AW'(1);
			end
			S_B_RD: cmd.cd_rd = 1'b1;
			S_B_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.msel   = MS_CP_NXT;
			end
			S_B_WR: begin
				cmd.bwd_wr = 1'b1;
				addr       = i_q + AW'(1);
			end
			S_BND_L: begin
				cmd.bnd_l = 1'b1;
				addr      = '0;
			end
			S_BND_R: begin
				cmd.bnd_r = 1'b1;
				addr      = last_idx;
			end
			S_E_RD: cmd.tmp_rd = 1'b1;
			S_E_CAP: begin
				cmd.out_cap  = 1'b1;
				cmd.out_last = (i_q == last_idx);
			end
			S_E_HOLD: ;
			default: ;
		endcase
	end

endmodule

>>> design/heat_equation_implicit_step.sv
// channel   dir  payload                                  request moves
// item      in   op, point_index, sample                  load one point or run one step
// result    out  point_index_res, temperature, last       one point of the new row
// cfg       in   write_enable, reg_index, write_data      register write
//
// A load writes one point of the row. A step runs the forward sweep over the
// interior points, each waiting on the bit-serial dividers (69 quotient bits, one
// per cycle), then the back sweep, and then emits each point of the new row through
// the row read port; a step on two points skips both sweeps.
// Reset clears control and configuration only; the row is undefined until loaded.
// A stalled result holds the block; no item is taken until the row is drained.
module heat_equation_implicit_step import hes_pkg::*; #(
	parameter int MAX_POINTS    = DefMaxPoints,
	parameter int FRACTION_BITS = DefFracBits
) (
	input  logic               clk,
	input  logic               arst_n,
	hes_in_if.sink             item,
	hes_out_if.source          result,
	input  logic               write_enable,
	input  logic [RegIdxW-1:0] reg_index,
	input  logic [DataW-1:0]   write_data
);

	localparam int AW = $clog2(MAX_POINTS);

	hes_cmd_t      cmd;
	hes_stat_t     stat;
	logic [AW-1:0] addr;
	logic [AW-1:0] last_idx;

	hes_ctrl #(.AW(AW)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item.valid),
		.item_op(item.op),
		.item_ready(item.ready),
		.res_valid(result.valid),
		.res_ready(result.ready),
		.last_idx(last_idx),
		.stat(stat),
		.cmd(cmd),
		.addr(addr)
	);

	hes_datapath #(.MAX_POINTS(MAX_POINTS), .FRACTION_BITS(FRACTION_BITS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.write_enable(write_enable),
		.reg_index(reg_index),
		.write_data(write_data),
		.point_index(item.point_index),
		.sample(item.sample),
		.cmd(cmd),
		.addr(addr),
		.stat(stat),
		.last_idx(last_idx),
		.point_index_res(result.point_index_res),
		.temperature(result.temperature),
		.last(result.last)
	);

endmodule

>>> design/hes_chk.sv
`include "assert_macros.svh"

module hes_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        item_op,
	input logic        res_valid,
	input logic        res_ready,
	input logic        res_last,
	input logic [5:0]  res_index,
	input logic [31:0] res_temp
);

	`HES_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_temp) && $stable(res_index), "stalled result changed")

	`HES_ASSERT_NOW(a_busy_emit, clk, arst_n, res_valid, !item_ready, "item taken while row is emitted")

	`HES_ASSERT_NEXT(a_step_busy, clk, arst_n, item_valid && item_ready && item_op, !item_ready, "block ready right after a step request")

	`HES_ASSERT_NEXT(a_last_ends, clk, arst_n, res_valid && res_ready && res_last, !res_valid, "result after the last point")

endmodule

bind heat_equation_implicit_step hes_chk u_hes_chk (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item.valid),
	.item_ready(item.ready),
	.item_op(item.op),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.res_last(result.last),
	.res_index(result.point_index_res),
	.res_temp(result.temperature)
);
